// File: design/lpfs_pkg.sv
// ----------------------------------------------------------------------------
// lpfs_pkg
// Shared constants, codes and types for the LED panel frame store scanner.
// ----------------------------------------------------------------------------
package lpfs_pkg;

    // panel tiling
    localparam int PANELS_WIDE = 2;
    localparam int PANELS_HIGH = 2;
    localparam int PANEL_COLS  = 32;
    localparam int PANEL_ROWS  = 16;
    localparam int PANEL_COUNT = PANELS_WIDE * PANELS_HIGH;

    // store geometry
    localparam int ROW_BYTES   = PANEL_COUNT * 4;
    localparam int STORE_BYTES = PANEL_COUNT * 64;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int COL_W       = $clog2(ROW_BYTES);
    localparam int X_LIMIT     = PANEL_COLS * PANELS_WIDE;
    localparam int Y_LIMIT     = PANEL_ROWS * PANELS_HIGH;
    localparam int GROUPS      = 4;

    localparam logic [15:0] DUTY_RESET = 16'd20000;
    localparam logic [7:0]  FILL_OFF   = 8'hFF;
    localparam logic [7:0]  FILL_LIT   = 8'h00;

    // action codes
    localparam logic [1:0] ACT_PIXEL = 2'd0;
    localparam logic [1:0] ACT_CLEAR = 2'd1;
    localparam logic [1:0] ACT_SCAN  = 2'd2;

    // draw mode codes
    localparam logic [2:0] MODE_NORMAL  = 3'd0;
    localparam logic [2:0] MODE_INVERSE = 3'd1;
    localparam logic [2:0] MODE_TOGGLE  = 3'd2;
    localparam logic [2:0] MODE_OR_ON   = 3'd3;
    localparam logic [2:0] MODE_NOR_OFF = 3'd4;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_PIX_WR,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

    typedef struct packed {
        logic        strobe;
        logic        result_kind;
        logic [7:0]  shift_byte;
        logic [1:0]  row_select;
        logic [15:0] enable_duty;
        logic        last_of_run;
    } result_t;

endpackage

// File: design/led_panel_frame_store_scan_core.sv
// ----------------------------------------------------------------------------
// led_panel_frame_store_scan_core
// Frame store and row-group scanner for tiled 32x16 one-bit LED panels.
// ----------------------------------------------------------------------------
// Items are taken on start while busy is low; results come out one per
// cycle on result_strobe and cannot be held off, so the receiver must take
// every strobed result. Timing is set by the single frame store memory
// (one read and one write port, registered read data):
//   - pixel write: the byte is read in the accept cycle, then modified and
//     written back in ST_PIX_WR with busy high; the
//     acknowledgement appears in the cycle busy drops.
//   - clear: writes all STORE_BYTES bytes (256 here) with busy high, one
//     byte per cycle; the acknowledgement appears in the cycle busy drops.
//   - scan: reads 4*ROW_BYTES bytes (64 here) with busy high, one byte per
//     cycle; each result follows its read in the next cycle, so the last
//     byte comes out in the cycle busy drops.
//   - undefined action: taken and dropped with busy staying low, no result.
// After reset the block fills the store with 0xFF, busy high throughout;
// configuration writes are taken at any time.
// busy is held through every multi-cycle transaction, so a pixel write can
// never overlap an access to the same byte and no forwarding is needed.
// Scan data goes out row3, row2, row1, row0 for each column byte; the final
// byte carries row_select (the phase before it advances) and enable_duty.
// ----------------------------------------------------------------------------
module led_panel_frame_store_scan_core (
    input  logic        clk,
    input  logic        rst_n,

    // command
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic [7:0]  pixel_x,
    input  logic [7:0]  pixel_y,
    input  logic [2:0]  draw_mode,
    input  logic        pixel_on,

    // brightness register
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,

    // results
    output logic        result_strobe,
    output logic        result_kind,
    output logic [7:0]  shift_byte,
    output logic [1:0]  row_select,
    output logic [15:0] enable_duty,
    output logic        last_of_run
);

    logic [15:0]        duty_reg;
    lpfs_pkg::ram_req_t ram_req;
    lpfs_pkg::result_t  result;
    logic [7:0]         rdata;

    // register is always writable; users write it only between transactions
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_reg <= lpfs_pkg::DUTY_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            duty_reg <= cfg_data;
        end
    end

    lpfs_store_ram u_store (
        .clk   (clk),
        .req   (ram_req),
        .rdata (rdata)
    );

    lpfs_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .action    (action),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .draw_mode (draw_mode),
        .pixel_on  (pixel_on),
        .duty      (duty_reg),
        .rdata     (rdata),
        .busy      (busy),
        .ram_req   (ram_req),
        .result    (result)
    );

    assign result_strobe = result.strobe;
    assign result_kind   = result.result_kind;
    assign shift_byte    = result.shift_byte;
    assign row_select    = result.row_select;
    assign enable_duty   = result.enable_duty;
    assign last_of_run   = result.last_of_run;

endmodule

// File: design/lpfs_store_ram.sv
// ----------------------------------------------------------------------------
// lpfs_store_ram
// Frame byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lpfs_store_ram (
    input  logic               clk,
    input  lpfs_pkg::ram_req_t req,
    output logic [7:0]         rdata
);

    logic [7:0] mem [lpfs_pkg::STORE_BYTES];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/lpfs_draw.sv
// ----------------------------------------------------------------------------
// lpfs_draw
// Modify step of the pixel read-modify-write: applies a draw mode to a byte.
// ----------------------------------------------------------------------------
module lpfs_draw (
    input  logic [7:0] old_byte,
    input  logic [2:0] draw_mode,
    input  logic       pixel_on,
    input  logic [2:0] bit_sel,
    output logic [7:0] new_byte
);

    logic [7:0] mask;

    assign mask = 8'h80 >> bit_sel;

    // a 0 bit means lit
    always_comb
    begin
        new_byte = old_byte;
        case (draw_mode)
            lpfs_pkg::MODE_NORMAL:
            begin
                new_byte = pixel_on ? (old_byte & ~mask) : (old_byte | mask);
            end
            lpfs_pkg::MODE_INVERSE:
            begin
                new_byte = pixel_on ? (old_byte | mask) : (old_byte & ~mask);
            end
            lpfs_pkg::MODE_TOGGLE:
            begin
                if (pixel_on)
                begin
                    new_byte = old_byte ^ mask;
                end
            end
            lpfs_pkg::MODE_OR_ON:
            begin
                if (pixel_on)
                begin
                    new_byte = old_byte & ~mask;
                end
            end
            lpfs_pkg::MODE_NOR_OFF:
            begin
                if (pixel_on && ((old_byte & mask) == 8'h00))
                begin
                    new_byte = old_byte | mask;
                end
            end
            default:
            begin
                new_byte = old_byte;
            end
        endcase
    end

endmodule

// File: design/lpfs_seq.sv
// ----------------------------------------------------------------------------
// lpfs_seq
// Sequencer: reset fill, clear sweep, pixel read-modify-write, row group scan.
// ----------------------------------------------------------------------------
module lpfs_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [1:0]         action,
    input  logic [7:0]         pixel_x,
    input  logic [7:0]         pixel_y,
    input  logic [2:0]         draw_mode,
    input  logic               pixel_on,
    input  logic [15:0]        duty,
    input  logic [7:0]         rdata,
    output logic               busy,
    output lpfs_pkg::ram_req_t ram_req,
    output lpfs_pkg::result_t  result
);

    localparam int AW = lpfs_pkg::ADDR_W;
    localparam int CW = lpfs_pkg::COL_W;

    lpfs_pkg::state_t state_reg, state_next;

    logic [AW-1:0] sweep_reg, sweep_next;
    logic [CW-1:0] col_reg, col_next;
    logic [1:0]    grp_reg, grp_next;
    logic [1:0]    phase_reg, phase_next;

    // latched item payload
    logic [7:0]    fill_reg;
    logic [AW-1:0] pix_addr_reg;
    logic          pix_ok_reg;
    logic [2:0]    mode_reg;
    logic          on_reg;
    logic [2:0]    bit_reg;

    // result registers
    logic        strobe_reg, strobe_next;
    logic        kind_reg, kind_next;
    logic [1:0]  sel_reg, sel_next;
    logic [15:0] duty_reg, duty_next;
    logic        last_reg, last_next;

    logic          accept;
    logic          sweep_end;
    logic          scan_end;
    logic          pix_ok;
    logic [AW-1:0] pix_addr;
    logic [AW-1:0] scan_addr;
    logic [7:0]    drawn;

    assign accept    = start && (state_reg == lpfs_pkg::ST_IDLE);
    assign sweep_end = (sweep_reg == AW'(lpfs_pkg::STORE_BYTES - 1));
    assign scan_end  = (col_reg == CW'(lpfs_pkg::ROW_BYTES - 1)) &&
                       (grp_reg == 2'(lpfs_pkg::GROUPS - 1));

    // tiling map of the pixel coordinates on the ports
    always_comb
    begin
        int px;
        int py;
        int panel;
        int col;
        px       = int'(pixel_x);
        py       = int'(pixel_y);
        pix_ok   = (px < lpfs_pkg::X_LIMIT) && (py < lpfs_pkg::Y_LIMIT);
        panel    = px / lpfs_pkg::PANEL_COLS +
                   lpfs_pkg::PANELS_WIDE * (py / lpfs_pkg::PANEL_ROWS);
        col      = px % lpfs_pkg::PANEL_COLS + panel * lpfs_pkg::PANEL_COLS;
        pix_addr = AW'(col / 8 + (py % lpfs_pkg::PANEL_ROWS) * lpfs_pkg::ROW_BYTES);
    end

    // row3..row0 of the current column byte
    always_comb
    begin
        int base;
        base      = lpfs_pkg::ROW_BYTES * int'(phase_reg) + int'(col_reg);
        scan_addr = AW'(base + (lpfs_pkg::GROUPS - 1 - int'(grp_reg)) *
                               lpfs_pkg::ROW_BYTES * lpfs_pkg::GROUPS);
    end

    lpfs_draw u_draw (
        .old_byte  (rdata),
        .draw_mode (mode_reg),
        .pixel_on  (on_reg),
        .bit_sel   (bit_reg),
        .new_byte  (drawn)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        sweep_next = sweep_reg;
        col_next   = col_reg;
        grp_next   = grp_reg;
        phase_next = phase_reg;
        case (state_reg)
            lpfs_pkg::ST_INIT,
            lpfs_pkg::ST_CLEAR:
            begin
                sweep_next = sweep_reg + 1'b1;
                if (sweep_end)
                begin
                    state_next = lpfs_pkg::ST_IDLE;
                end
            end
            lpfs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (action)
                        lpfs_pkg::ACT_PIXEL:
                        begin
                            state_next = lpfs_pkg::ST_PIX_WR;
                        end
                        lpfs_pkg::ACT_CLEAR:
                        begin
                            state_next = lpfs_pkg::ST_CLEAR;
                            sweep_next = '0;
                        end
                        lpfs_pkg::ACT_SCAN:
                        begin
                            state_next = lpfs_pkg::ST_SCAN;
                            col_next   = '0;
                            grp_next   = '0;
                        end
                        default:
                        begin
                            state_next = lpfs_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            lpfs_pkg::ST_PIX_WR:
            begin
                state_next = lpfs_pkg::ST_IDLE;
            end
            lpfs_pkg::ST_SCAN:
            begin
                grp_next = grp_reg + 1'b1;
                if (grp_reg == 2'(lpfs_pkg::GROUPS - 1))
                begin
                    col_next = col_reg + 1'b1;
                end
                if (scan_end)
                begin
                    state_next = lpfs_pkg::ST_IDLE;
                    phase_next = phase_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = lpfs_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs: store access and next result
    always_comb
    begin
        busy          = (state_reg != lpfs_pkg::ST_IDLE);
        ram_req.we    = 1'b0;
        ram_req.waddr = sweep_reg;
        ram_req.wdata = fill_reg;
        ram_req.raddr = pix_addr;
        strobe_next   = 1'b0;
        kind_next     = 1'b0;
        sel_next      = 2'd0;
        duty_next     = 16'd0;
        last_next     = 1'b0;
        case (state_reg)
            lpfs_pkg::ST_INIT:
            begin
                ram_req.we    = 1'b1;
                ram_req.wdata = lpfs_pkg::FILL_OFF;
            end
            lpfs_pkg::ST_CLEAR:
            begin
                ram_req.we = 1'b1;
                if (sweep_end)
                begin
                    strobe_next = 1'b1;
                    last_next   = 1'b1;
                end
            end
            lpfs_pkg::ST_IDLE:
            begin
                ram_req.raddr = pix_addr;
            end
            lpfs_pkg::ST_PIX_WR:
            begin
                ram_req.we    = pix_ok_reg;
                ram_req.waddr = pix_addr_reg;
                ram_req.wdata = drawn;
                strobe_next   = 1'b1;
                last_next     = 1'b1;
            end
            lpfs_pkg::ST_SCAN:
            begin
                ram_req.raddr = scan_addr;
                strobe_next   = 1'b1;
                kind_next     = 1'b1;
                if (scan_end)
                begin
                    sel_next  = phase_reg;
                    duty_next = duty;
                    last_next = 1'b1;
                end
            end
            default:
            begin
                ram_req.we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= lpfs_pkg::ST_INIT;
            sweep_reg  <= '0;
            phase_reg  <= 2'd0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            sweep_reg  <= sweep_next;
            phase_reg  <= phase_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg  <= col_next;
        grp_reg  <= grp_next;
        kind_reg <= kind_next;
        sel_reg  <= sel_next;
        duty_reg <= duty_next;
        last_reg <= last_next;
        if (accept)
        begin
            fill_reg     <= pixel_on ? lpfs_pkg::FILL_OFF : lpfs_pkg::FILL_LIT;
            pix_addr_reg <= pix_addr;
            pix_ok_reg   <= pix_ok;
            mode_reg     <= draw_mode;
            on_reg       <= pixel_on;
            bit_reg      <= pixel_x[2:0];
        end
    end

    assign result.strobe      = strobe_reg;
    assign result.result_kind = kind_reg;
    assign result.shift_byte  = kind_reg ? rdata : 8'h00;
    assign result.row_select  = sel_reg;
    assign result.enable_duty = duty_reg;
    assign result.last_of_run = last_reg;

`ifndef ASSERT_OFF
    a_strobe_source: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |-> ($past(state_reg) == lpfs_pkg::ST_PIX_WR ||
                        $past(state_reg) == lpfs_pkg::ST_CLEAR ||
                        $past(state_reg) == lpfs_pkg::ST_SCAN))
        else $error("result strobe without a finishing item");

    a_phase_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lpfs_pkg::ST_SCAN && scan_end) |=>
            (phase_reg == $past(phase_reg) + 2'd1))
        else $error("scan phase did not advance after a row group");

    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        ram_req.we |-> (state_reg != lpfs_pkg::ST_IDLE &&
                        state_reg != lpfs_pkg::ST_SCAN))
        else $error("store written outside fill or pixel update");

    a_tail_only: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && !last_reg) |-> (sel_reg == 2'd0 && duty_reg == 16'd0))
        else $error("row select or duty on a non-final result");
`endif

endmodule

// File: tb/led_panel_frame_store_scan_core_tb.sv
// ----------------------------------------------------------------------------
// led_panel_frame_store_scan_core_tb
// Self-checking bench for the LED panel frame store and row-group scanner.
// Keeps its own copy of the frame store, scan phase and brightness duty.
// Every accepted command is run through that copy to build the expected
// result transactions, and every strobed result is checked against them in
// order. Stimulus is a directed sweep of draw modes and edge coordinates,
// then bursts of random commands under several brightness settings.
// ----------------------------------------------------------------------------
module led_panel_frame_store_scan_core_tb;

    // Codes the package leaves unnamed: the spare action and spare draw modes.
    localparam logic [1:0] ACT_UNUSED     = 2'd3;
    localparam logic [2:0] MODE_SPARE_LO  = 3'd5;
    localparam logic [2:0] MODE_SPARE_HI  = 3'd7;
    localparam int         REPORT_LIMIT   = 10;
    localparam int         DRAIN_GUARD    = 4096;
    localparam int         SETTLE_CYCLES  = 4;

    // ------------------------------------------------------------------------
    // Frame store predictor and result scoreboard
    // ------------------------------------------------------------------------
    class frame_store_model;
        logic [7:0]         pixels [lpfs_pkg::STORE_BYTES];
        logic [1:0]         phase;
        logic [15:0]        duty;
        lpfs_pkg::result_t  pending_results [$];
        int                 mismatches;
        int                 results_seen;
        int                 n_pixel;
        int                 n_clear;
        int                 n_scan;
        int                 n_dropped;

        function new();
            foreach (pixels[i])
                pixels[i] = lpfs_pkg::FILL_OFF;
            phase        = 2'd0;
            duty         = lpfs_pkg::DUTY_RESET;
            mismatches   = 0;
            results_seen = 0;
            n_pixel      = 0;
            n_clear      = 0;
            n_scan       = 0;
            n_dropped    = 0;
        endfunction

        function lpfs_pkg::result_t make_result(logic kind, logic [7:0] value,
                                                logic [1:0] sel, logic [15:0] pwm,
                                                logic last);
            lpfs_pkg::result_t r;
            r.strobe      = 1'b1;
            r.result_kind = kind;
            r.shift_byte  = value;
            r.row_select  = sel;
            r.enable_duty = pwm;
            r.last_of_run = last;
            return r;
        endfunction

        // Read-modify-write of one store byte; a stored 0 means lit.
        function void draw(logic [7:0] x, logic [7:0] y, logic [2:0] mode, logic on);
            int         panel;
            int         col;
            int         row;
            int         addr;
            logic [7:0] mask;
            logic [7:0] b;
            if (x >= lpfs_pkg::X_LIMIT || y >= lpfs_pkg::Y_LIMIT)
                return;
            panel = x / lpfs_pkg::PANEL_COLS +
                    lpfs_pkg::PANELS_WIDE * (y / lpfs_pkg::PANEL_ROWS);
            col   = x % lpfs_pkg::PANEL_COLS + panel * lpfs_pkg::PANEL_COLS;
            row   = y % lpfs_pkg::PANEL_ROWS;
            addr  = col / 8 + row * lpfs_pkg::ROW_BYTES;
            mask  = 8'h80 >> (col % 8);
            b     = pixels[addr];
            case (mode)
                lpfs_pkg::MODE_NORMAL:  b = on ? (b & ~mask) : (b | mask);
                lpfs_pkg::MODE_INVERSE: b = on ? (b | mask) : (b & ~mask);
                lpfs_pkg::MODE_TOGGLE:  if (on) b = b ^ mask;
                lpfs_pkg::MODE_OR_ON:   if (on) b = b & ~mask;
                lpfs_pkg::MODE_NOR_OFF: if (on && (b & mask) == 8'h00) b = b | mask;
                default: ;
            endcase
            pixels[addr] = b;
        endfunction

        function void note_command(logic [1:0] act, logic [7:0] x, logic [7:0] y,
                                   logic [2:0] mode, logic on);
            int   base;
            int   addr;
            logic last;
            case (act)
                lpfs_pkg::ACT_PIXEL:
                begin
                    n_pixel++;
                    draw(x, y, mode, on);
                    pending_results.push_back(make_result(1'b0, 8'h00, 2'd0, 16'd0, 1'b1));
                end
                lpfs_pkg::ACT_CLEAR:
                begin
                    n_clear++;
                    foreach (pixels[i])
                        pixels[i] = on ? lpfs_pkg::FILL_OFF : lpfs_pkg::FILL_LIT;
                    pending_results.push_back(make_result(1'b0, 8'h00, 2'd0, 16'd0, 1'b1));
                end
                lpfs_pkg::ACT_SCAN:
                begin
                    n_scan++;
                    base = lpfs_pkg::ROW_BYTES * phase;
                    // per column byte: row3, row2, row1, row0 of the group
                    for (int i = 0; i < lpfs_pkg::ROW_BYTES; i++)
                    begin
                        for (int g = 0; g < lpfs_pkg::GROUPS; g++)
                        begin
                            addr = base + i + (lpfs_pkg::GROUPS - 1 - g) *
                                   lpfs_pkg::ROW_BYTES * lpfs_pkg::GROUPS;
                            last = (i == lpfs_pkg::ROW_BYTES - 1) &&
                                   (g == lpfs_pkg::GROUPS - 1);
                            pending_results.push_back(make_result(1'b1, pixels[addr],
                                last ? phase : 2'd0, last ? duty : 16'd0, last));
                        end
                    end
                    phase = phase + 2'd1;
                end
                default: n_dropped++;
            endcase
        endfunction

        function void check_result(logic kind, logic [7:0] value, logic [1:0] sel,
                                   logic [15:0] pwm, logic last);
            lpfs_pkg::result_t want;
            results_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("result %0d unexpected: kind %0d byte %02h sel %0d duty %0d last %0d",
                             results_seen, kind, value, sel, pwm, last);
                return;
            end
            want = pending_results.pop_front();
            if (kind !== want.result_kind || value !== want.shift_byte ||
                sel !== want.row_select || pwm !== want.enable_duty ||
                last !== want.last_of_run)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("result %0d: expected kind %0d byte %02h sel %0d duty %0d last %0d",
                             results_seen, want.result_kind, want.shift_byte,
                             want.row_select, want.enable_duty, want.last_of_run);
                    $display("result %0d: actual   kind %0d byte %02h sel %0d duty %0d last %0d",
                             results_seen, kind, value, sel, pwm, last);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------------
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        start     = 1'b0;
    logic [1:0]  action    = lpfs_pkg::ACT_PIXEL;
    logic [7:0]  pixel_x   = 8'd0;
    logic [7:0]  pixel_y   = 8'd0;
    logic [2:0]  draw_mode = lpfs_pkg::MODE_NORMAL;
    logic        pixel_on  = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [15:0] cfg_data  = 16'd0;
    logic        busy;
    logic        cfg_ready;
    logic        result_strobe;
    logic        result_kind;
    logic [7:0]  shift_byte;
    logic [1:0]  row_select;
    logic [15:0] enable_duty;
    logic        last_of_run;

    frame_store_model sb = new();
    int               settings_used = 0;

    always #2 clk = ~clk;

    led_panel_frame_store_scan_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .draw_mode     (draw_mode),
        .pixel_on      (pixel_on),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .result_strobe (result_strobe),
        .result_kind   (result_kind),
        .shift_byte    (shift_byte),
        .row_select    (row_select),
        .enable_duty   (enable_duty),
        .last_of_run   (last_of_run)
    );

    // ------------------------------------------------------------------------
    // Monitor: all inputs change by NBA on the edge, so values read here are
    // the ones the DUT saw. Results go first; a command accepted on the same
    // edge only appends behind what is already queued.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_strobe)
                sb.check_result(result_kind, shift_byte, row_select, enable_duty, last_of_run);
            if (start && !busy)
                sb.note_command(action, pixel_x, pixel_y, draw_mode, pixel_on);
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Hold start high until the command transaction is taken. start is left
    // high so back-to-back commands need no extra NBA on it.
    task automatic send_command(logic [1:0] act, logic [7:0] x, logic [7:0] y,
                                logic [2:0] mode, logic on);
        start     <= 1'b1;
        action    <= act;
        pixel_x   <= x;
        pixel_y   <= y;
        draw_mode <= mode;
        pixel_on  <= on;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic pause_sender(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Wait for every expected result and for busy to drop, then let the
    // bench settle for SETTLE_CYCLES before going on.
    task automatic drain();
        int guard;
        guard = 0;
        start <= 1'b0;
        @(posedge clk);
        while ((sb.pending_results.size() != 0 || busy) && guard < DRAIN_GUARD)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Brightness register write; only issued while the block is idle.
    task automatic write_duty(logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.duty = value;
        settings_used++;
        cfg_valid <= 1'b0;
    endtask

    // Random commands in bursts. Mostly in-range pixel writes so the store
    // fills with a pattern, frequent scans to read it back, rare clears and
    // a sprinkling of out-of-range coordinates, spare modes and the spare
    // action.
    task automatic run_random(int count);
        int         burst;
        int         pick;
        logic [1:0] act;
        logic [7:0] x;
        logic [7:0] y;
        logic [2:0] mode;
        logic       on;
        burst = $urandom_range(1, 12);
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 62)
                act = lpfs_pkg::ACT_PIXEL;
            else if (pick < 66)
                act = lpfs_pkg::ACT_CLEAR;
            else if (pick < 95)
                act = lpfs_pkg::ACT_SCAN;
            else
                act = ACT_UNUSED;
            if ($urandom_range(0, 9) < 8)
            begin
                x = 8'($urandom_range(0, lpfs_pkg::X_LIMIT - 1));
                y = 8'($urandom_range(0, lpfs_pkg::Y_LIMIT - 1));
            end
            else
            begin
                x = 8'($urandom);
                y = 8'($urandom);
            end
            if ($urandom_range(0, 9) == 0)
                mode = 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
            else
                mode = 3'($urandom_range(lpfs_pkg::MODE_NORMAL, lpfs_pkg::MODE_NOR_OFF));
            on = 1'($urandom_range(0, 1));
            send_command(act, x, y, mode, on);
            burst--;
            if (burst == 0)
            begin
                burst = $urandom_range(1, 12);
                pause_sender($urandom_range(1, 8));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [15:0] duty_plan [5];
        logic [7:0]  x_last;
        logic [7:0]  y_last;
        logic [7:0]  x_past;
        logic [7:0]  y_past;
        duty_plan[0] = 16'hFFFF;
        duty_plan[1] = 16'h0000;
        duty_plan[2] = 16'($urandom);
        duty_plan[3] = 16'h0001;
        duty_plan[4] = 16'($urandom);
        x_last       = 8'(lpfs_pkg::X_LIMIT - 1);
        y_last       = 8'(lpfs_pkg::Y_LIMIT - 1);
        x_past       = 8'(lpfs_pkg::X_LIMIT);
        y_past       = 8'(lpfs_pkg::Y_LIMIT);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed sweep at the reset brightness. The first command waits
        // out the power-up fill through busy.
        send_command(lpfs_pkg::ACT_SCAN,  8'd0, 8'd0, lpfs_pkg::MODE_NORMAL, 1'b0); // blank
        send_command(lpfs_pkg::ACT_PIXEL, 8'd0, 8'd0, lpfs_pkg::MODE_NORMAL, 1'b1); // corner
        send_command(lpfs_pkg::ACT_PIXEL, x_last, y_last, lpfs_pkg::MODE_NORMAL, 1'b1);
        send_command(lpfs_pkg::ACT_PIXEL, 8'd255, 8'd255, lpfs_pkg::MODE_NORMAL, 1'b1);
        send_command(lpfs_pkg::ACT_PIXEL, x_past, 8'd0, lpfs_pkg::MODE_NORMAL, 1'b1);
        send_command(lpfs_pkg::ACT_PIXEL, 8'd0, y_past, lpfs_pkg::MODE_NORMAL, 1'b1);
        send_command(lpfs_pkg::ACT_PIXEL, x_last, 8'd0, lpfs_pkg::MODE_NORMAL, 1'b1);
        send_command(lpfs_pkg::ACT_PIXEL, 8'd0, y_last, lpfs_pkg::MODE_NORMAL, 1'b1);
        send_command(lpfs_pkg::ACT_SCAN,  8'd0, 8'd0, lpfs_pkg::MODE_NORMAL, 1'b0);
        send_command(lpfs_pkg::ACT_PIXEL, 8'd0, 8'd0, lpfs_pkg::MODE_NORMAL, 1'b0);
        send_command(lpfs_pkg::ACT_PIXEL, 8'd9, 8'd17, lpfs_pkg::MODE_INVERSE, 1'b0);
        send_command(lpfs_pkg::ACT_PIXEL, 8'd10, 8'd17, lpfs_pkg::MODE_INVERSE, 1'b1);
        send_command(lpfs_pkg::ACT_PIXEL, 8'd40, 8'd3, lpfs_pkg::MODE_TOGGLE, 1'b1);
        send_command(lpfs_pkg::ACT_PIXEL, 8'd40, 8'd3, lpfs_pkg::MODE_TOGGLE, 1'b0); // no-op
        send_command(lpfs_pkg::ACT_PIXEL, 8'd33, 8'd20, lpfs_pkg::MODE_OR_ON, 1'b1);
        send_command(lpfs_pkg::ACT_PIXEL, 8'd34, 8'd20, lpfs_pkg::MODE_OR_ON, 1'b0);
        send_command(lpfs_pkg::ACT_PIXEL, 8'd33, 8'd20, lpfs_pkg::MODE_NOR_OFF, 1'b1);
        send_command(lpfs_pkg::ACT_PIXEL, 8'd35, 8'd20, lpfs_pkg::MODE_NOR_OFF, 1'b1);
        send_command(lpfs_pkg::ACT_PIXEL, 8'd5, 8'd5, MODE_SPARE_LO, 1'b1); // ack only
        send_command(lpfs_pkg::ACT_PIXEL, 8'd5, 8'd5, MODE_SPARE_HI, 1'b1);
        send_command(ACT_UNUSED, 8'd255, 8'd255, MODE_SPARE_HI, 1'b1);      // no result
        send_command(lpfs_pkg::ACT_SCAN,  8'd0, 8'd0, lpfs_pkg::MODE_NORMAL, 1'b0);
        send_command(lpfs_pkg::ACT_SCAN,  8'd0, 8'd0, lpfs_pkg::MODE_NORMAL, 1'b0);
        send_command(lpfs_pkg::ACT_SCAN,  8'd0, 8'd0, lpfs_pkg::MODE_NORMAL, 1'b0); // phase 0 again
        send_command(lpfs_pkg::ACT_CLEAR, 8'd0, 8'd0, lpfs_pkg::MODE_NORMAL, 1'b0); // all lit
        send_command(lpfs_pkg::ACT_SCAN,  8'd0, 8'd0, lpfs_pkg::MODE_NORMAL, 1'b0);
        send_command(lpfs_pkg::ACT_CLEAR, 8'd0, 8'd0, lpfs_pkg::MODE_NORMAL, 1'b1); // all dark

        // Random phases, each under its own brightness setting.
        for (int p = 0; p < 5; p++)
        begin
            drain();
            write_duty(duty_plan[p]);
            run_random(50);
        end

        drain();
        if (sb.pending_results.size() != 0)
        begin
            $display("%0d expected results never arrived", sb.pending_results.size());
            sb.mismatches += sb.pending_results.size();
        end

        $display("covered %0d pixel writes, %0d clears, %0d scans, %0d undefined commands",
                 sb.n_pixel, sb.n_clear, sb.n_scan, sb.n_dropped);
        $display("%0d results checked over %0d brightness writes, %0d mismatches",
                 sb.results_seen, settings_used, sb.mismatches);
        if (sb.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Hard stop well past the slowest legal run.
    initial
    begin
        #2000000;
        $display("timeout: block stopped responding");
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: led_panel_frame_store_scan_core.f
design/lpfs_pkg.sv
design/lpfs_store_ram.sv
design/lpfs_draw.sv
design/lpfs_seq.sv
design/led_panel_frame_store_scan_core.sv
tb/led_panel_frame_store_scan_core_tb.sv
